// ----- hdl/image_frame_deframer_unit_defines.svh -----
// Assertion helpers for the deframer. Both sample on clk and stay quiet while arst_n is low.
`ifndef IMAGE_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define IMAGE_FRAME_DEFRAMER_UNIT_DEFINES_SVH

// Require cons in the same cycle as ante.
`define IFD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Require cons in the cycle after ante.
`define IFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/ifd_pkg.sv -----
`timescale 1ns / 1ps
package ifd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned WORD_W = 32;

	// register file
	localparam logic [WORD_W-1:0] MAGIC_RST     = 32'h4C5A_445A;
	localparam logic [WORD_W-1:0] MAX_BYTES_RST = 32'd5242880;
	typedef logic [0:0] reg_idx_t;
	localparam reg_idx_t REG_MAGIC     = 1'b0;
	localparam reg_idx_t REG_MAX_BYTES = 1'b1;

	// result kinds
	typedef logic [1:0] event_kind_t;
	localparam event_kind_t EV_PIXEL       = 2'd0;
	localparam event_kind_t EV_REJECT      = 2'd1;
	localparam event_kind_t EV_UNSUPPORTED = 2'd2;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_LEN  = 3'd1,
		PH_ROWS = 3'd2,
		PH_COLS = 3'd3,
		PH_DATA = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		MODE_RGB  = 2'd0,
		MODE_GRAY = 2'd1,
		MODE_SKIP = 2'd2
	} mode_t;

	typedef struct packed {
		logic                valid;
		event_kind_t         event_kind;
		logic [BYTE_W-1:0]   red;
		logic [BYTE_W-1:0]   green;
		logic [BYTE_W-1:0]   blue;
		logic                is_gray;
		logic [WORD_W-1:0]   frame_width;
		logic [WORD_W-1:0]   frame_height;
		logic                first_pixel;
		logic                last_pixel;
	} result_t;

endpackage

// ----- hdl/ifd_byte_if.sv -----
`timescale 1ns / 1ps
interface ifd_byte_if;
	import ifd_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- hdl/ifd_pix_if.sv -----
`timescale 1ns / 1ps
interface ifd_pix_if;
	import ifd_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        event_kind;
	logic [BYTE_W-1:0] red;
	logic [BYTE_W-1:0] green;
	logic [BYTE_W-1:0] blue;
	logic              is_gray;
	logic [WORD_W-1:0] frame_width;
	logic [WORD_W-1:0] frame_height;
	logic              first_pixel;
	logic              last_pixel;

	modport source (output valid, output event_kind, output red, output green, output blue,
		output is_gray, output frame_width, output frame_height, output first_pixel,
		output last_pixel, input ready);
	modport sink (input valid, input event_kind, input red, input green, input blue,
		input is_gray, input frame_width, input frame_height, input first_pixel,
		input last_pixel, output ready);
endinterface

// ----- hdl/image_frame_deframer_unit.sv -----
`timescale 1ns / 1ps
`include "image_frame_deframer_unit_defines.svh"
// Byte-stream deframer: takes one received byte per word on rx, finds the marker in
// magic_word, reads the length, rows and columns header words, and sends pixels, reject
// events or unsupported-size events on px. A byte is taken every cycle as long as px
// drains; a result passes through the input register and then the result register
// before it is offered on px. The rate is set by the single parse stage, which updates
// all state for one byte per cycle while px is not stalled; the rows*cols product is
// built over the four column bytes with one 32x8 multiply-add per byte, so the end of
// the header needs no wide multiply. Write registers only while no byte is in flight.
// No clearing pass after reset.
module image_frame_deframer_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  ifd_pkg::reg_idx_t                  cfg_index,
	input  logic [ifd_pkg::WORD_W-1:0]         cfg_wdata,
	ifd_byte_if.sink                           rx,
	ifd_pix_if.source                          px
);
	import ifd_pkg::*;

	logic [WORD_W-1:0] magic_q;
	logic [WORD_W-1:0] max_bytes_q;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              advance;
	result_t           res;
	result_t           out_q;
	logic              out_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q     <= MAGIC_RST;
			max_bytes_q <= MAX_BYTES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAGIC:     magic_q     <= cfg_wdata;
				REG_MAX_BYTES: max_bytes_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// advance the held word when the result register can take its outcome
	assign advance  = valid_s1 && (!out_valid_q || px.ready);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	ifd_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (advance),
		.rx_byte         (byte_s1),
		.magic_word      (magic_q),
		.max_image_bytes (max_bytes_q),
		.res             (res)
	);

	// result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (px.ready || !out_valid_q) begin
			out_valid_q <= advance && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			out_q <= res;
		end
	end

	assign px.valid        = out_valid_q;
	assign px.event_kind   = out_q.event_kind;
	assign px.red          = out_q.red;
	assign px.green        = out_q.green;
	assign px.blue         = out_q.blue;
	assign px.is_gray      = out_q.is_gray;
	assign px.frame_width  = out_q.frame_width;
	assign px.frame_height = out_q.frame_height;
	assign px.first_pixel  = out_q.first_pixel;
	assign px.last_pixel   = out_q.last_pixel;

	`IFD_ASSERT_NEXT(a_hold_s1, valid_s1 && out_valid_q && !px.ready, valid_s1 && $stable(byte_s1), "held word lost under stall")
	`IFD_ASSERT_SAME(a_ready_when_empty, !out_valid_q, rx.ready, "input stalled with empty result register")
	`IFD_ASSERT_SAME(a_gray_equal, px.valid && px.is_gray, px.red == px.green && px.green == px.blue && px.event_kind == EV_PIXEL, "gray pixel channels differ")
	`IFD_ASSERT_SAME(a_reject_clear, px.valid && px.event_kind == EV_REJECT, px.frame_width == '0 && px.frame_height == '0 && !px.first_pixel && !px.last_pixel, "reject event carries data")

endmodule

// ----- hdl/ifd_parser.sv -----
`timescale 1ns / 1ps
module ifd_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [ifd_pkg::BYTE_W-1:0]    rx_byte,
	input  logic [ifd_pkg::WORD_W-1:0]    magic_word,
	input  logic [ifd_pkg::WORD_W-1:0]    max_image_bytes,
	output ifd_pkg::result_t              res
);
	import ifd_pkg::*;

	phase_t              phase_q, phase_d;
	logic [23:0]         window_q, window_d;
	logic [1:0]          fill_q, fill_d;
	logic [23:0]         hdr_q, hdr_d;
	logic [1:0]          hcnt_q, hcnt_d;
	logic [WORD_W-1:0]   len_q, len_d;
	logic [WORD_W-1:0]   rows_q, rows_d;
	logic [WORD_W-1:0]   rows3_q, rows3_d;
	logic [WORD_W-1:0]   cols_q, cols_d;
	logic [WORD_W-1:0]   acc_q, acc_d;
	logic [WORD_W-1:0]   acc3_q, acc3_d;
	logic [WORD_W-1:0]   rem_q, rem_d;
	mode_t               mode_q, mode_d;
	logic [15:0]         part_q, part_d;
	logic [1:0]          bip_q, bip_d;
	logic                first_q, first_d;

	logic [WORD_W-1:0]   word;
	logic [WORD_W-1:0]   rem_dec;
	logic                last;
	logic [39:0]         row_prod;
	logic [39:0]         row3_prod;
	logic [WORD_W-1:0]   prod;
	logic [WORD_W-1:0]   prod3;

	// header word so far, and the pixel count built one column byte at a time
	assign word      = {hdr_q, rx_byte};
	assign row_prod  = rows_q * {32'd0, rx_byte};
	assign row3_prod = rows3_q * {32'd0, rx_byte};
	assign prod      = {acc_q[23:0], 8'h00} + row_prod[WORD_W-1:0];
	assign prod3     = {acc3_q[23:0], 8'h00} + row3_prod[WORD_W-1:0];
	assign rem_dec   = rem_q - 32'd1;
	assign last      = (rem_dec == '0);

	// next state and result for the current byte
	always_comb begin
		phase_d  = phase_q;
		window_d = window_q;
		fill_d   = fill_q;
		hdr_d    = hdr_q;
		hcnt_d   = hcnt_q;
		len_d    = len_q;
		rows_d   = rows_q;
		rows3_d  = rows3_q;
		cols_d   = cols_q;
		acc_d    = acc_q;
		acc3_d   = acc3_q;
		rem_d    = rem_q;
		mode_d   = mode_q;
		part_d   = part_q;
		bip_d    = bip_q;
		first_d  = first_q;
		res      = '0;

		case (phase_q)
			PH_LEN, PH_ROWS, PH_COLS: begin
				if (phase_q == PH_COLS) begin
					acc_d  = prod;
					acc3_d = prod3;
				end
				if (hcnt_q != 2'd3) begin
					hdr_d  = word[23:0];
					hcnt_d = hcnt_q + 2'd1;
				end else begin
					hdr_d  = '0;
					hcnt_d = '0;
					case (phase_q)
						PH_LEN: begin
							len_d = word;
							if (word == '0 || word > max_image_bytes) begin
								phase_d        = PH_HUNT;
								window_d       = '0;
								fill_d         = '0;
								res.valid      = 1'b1;
								res.event_kind = EV_REJECT;
							end else begin
								phase_d = PH_ROWS;
							end
						end
						PH_ROWS: begin
							rows_d  = word;
							rows3_d = word + {word[WORD_W-2:0], 1'b0};
							acc_d   = '0;
							acc3_d  = '0;
							phase_d = PH_COLS;
						end
						default: begin
							cols_d  = word;
							phase_d = PH_DATA;
							rem_d   = len_q;
							bip_d   = '0;
							part_d  = '0;
							first_d = 1'b1;
							if (len_q == prod3) begin
								mode_d = MODE_RGB;
							end else if (len_q == prod) begin
								mode_d = MODE_GRAY;
							end else begin
								mode_d           = MODE_SKIP;
								res.valid        = 1'b1;
								res.event_kind   = EV_UNSUPPORTED;
								res.frame_width  = word;
								res.frame_height = rows_q;
							end
						end
					endcase
				end
			end
			PH_DATA: begin
				rem_d = rem_dec;
				if (last) begin
					phase_d  = PH_HUNT;
					window_d = '0;
					fill_d   = '0;
				end
				res.event_kind   = EV_PIXEL;
				res.frame_width  = cols_q;
				res.frame_height = rows_q;
				res.first_pixel  = first_q;
				res.last_pixel   = last;
				case (mode_q)
					MODE_GRAY: begin
						res.valid   = 1'b1;
						res.red     = rx_byte;
						res.green   = rx_byte;
						res.blue    = rx_byte;
						res.is_gray = 1'b1;
						first_d     = 1'b0;
					end
					MODE_RGB: begin
						// bytes arrive blue, green, red
						case (bip_q)
							2'd0: begin
								part_d = {8'h00, rx_byte};
								bip_d  = 2'd1;
							end
							2'd1: begin
								part_d = {rx_byte, part_q[7:0]};
								bip_d  = 2'd2;
							end
							default: begin
								bip_d     = 2'd0;
								res.valid = 1'b1;
								res.red   = rx_byte;
								res.green = part_q[15:8];
								res.blue  = part_q[7:0];
								first_d   = 1'b0;
							end
						endcase
					end
					default: begin
						// drop the byte
					end
				endcase
			end
			default: begin
				// slide the window until the last four bytes match the marker
				if (fill_q == 2'd3 && {window_q, rx_byte} == magic_word) begin
					phase_d  = PH_LEN;
					window_d = '0;
					fill_d   = '0;
					hdr_d    = '0;
					hcnt_d   = '0;
				end else begin
					phase_d  = PH_HUNT;
					window_d = {window_q[15:0], rx_byte};
					if (fill_q != 2'd3) begin
						fill_d = fill_q + 2'd1;
					end
				end
			end
		endcase

		if (!step) begin
			res.valid = 1'b0;
		end
	end

	// commit state on each byte taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			window_q <= '0;
			fill_q   <= '0;
			hdr_q    <= '0;
			hcnt_q   <= '0;
			len_q    <= '0;
			rows_q   <= '0;
			rows3_q  <= '0;
			cols_q   <= '0;
			acc_q    <= '0;
			acc3_q   <= '0;
			rem_q    <= '0;
			mode_q   <= MODE_RGB;
			part_q   <= '0;
			bip_q    <= '0;
			first_q  <= 1'b1;
		end else if (step) begin
			phase_q  <= phase_d;
			window_q <= window_d;
			fill_q   <= fill_d;
			hdr_q    <= hdr_d;
			hcnt_q   <= hcnt_d;
			len_q    <= len_d;
			rows_q   <= rows_d;
			rows3_q  <= rows3_d;
			cols_q   <= cols_d;
			acc_q    <= acc_d;
			acc3_q   <= acc3_d;
			rem_q    <= rem_d;
			mode_q   <= mode_d;
			part_q   <= part_d;
			bip_q    <= bip_d;
			first_q  <= first_d;
		end
	end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;
	import ifd_pkg::*;

	// longest correct silence is the sink hold-off plus a few stalls
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam logic [WORD_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

	typedef enum int {
		SHAPE_RGB,
		SHAPE_GRAY,
		SHAPE_REJECT,
		SHAPE_UNSUPPORTED,
		SHAPE_WRAPPED,
		SHAPE_TRAILING
	} frame_shape_t;

	// Tracks the parser state per accepted byte and holds the results still due.
	class deframe_scoreboard;
		logic [WORD_W-1:0] magic = MAGIC_RST;
		logic [WORD_W-1:0] max_bytes = MAX_BYTES_RST;
		phase_t            ph = PH_HUNT;
		logic [23:0]       window = '0;
		logic [1:0]        fill = '0;
		logic [WORD_W-1:0] hdr = '0;
		logic [1:0]        hdr_cnt = '0;
		logic [WORD_W-1:0] data_len = '0;
		logic [WORD_W-1:0] rows = '0;
		logic [WORD_W-1:0] cols = '0;
		logic [WORD_W-1:0] remaining = '0;
		mode_t             mode = MODE_RGB;
		logic [15:0]       partial = '0;
		logic [1:0]        pix_idx = '0;
		logic              first_due = 1'b1;
		result_t           events_due[$];
		int                failures = 0;

		function void set_reg(reg_idx_t idx, logic [WORD_W-1:0] v);
			if (idx == REG_MAGIC) begin
				magic = v;
			end else begin
				max_bytes = v;
			end
		endfunction

		function void restart_hunt();
			ph = PH_HUNT;
			window = '0;
			fill = '0;
		endfunction

		function void due_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic gray,
			logic last);
			result_t px;
			px = '0;
			px.valid = 1'b1;
			px.event_kind = EV_PIXEL;
			px.red = r;
			px.green = g;
			px.blue = b;
			px.is_gray = gray;
			px.frame_width = cols;
			px.frame_height = rows;
			px.first_pixel = first_due;
			px.last_pixel = last;
			first_due = 1'b0;
			events_due.push_back(px);
		endfunction

		// advance the parser by one byte and queue whatever it emits
		function void take_byte(logic [7:0] b);
			result_t           ev;
			logic [WORD_W-1:0] word;
			logic [WORD_W-1:0] pc;
			logic [WORD_W-1:0] pc3;
			logic              last;
			ev = '0;
			ev.valid = 1'b1;
			case (ph)
				PH_LEN, PH_ROWS, PH_COLS: begin
					word = {hdr[23:0], b};
					if (hdr_cnt != 2'd3) begin
						hdr = word;
						hdr_cnt++;
						return;
					end
					hdr = '0;
					hdr_cnt = '0;
					if (ph == PH_LEN) begin
						data_len = word;
						if (word == 0 || word > max_bytes) begin
							restart_hunt();
							ev.event_kind = EV_REJECT;
							events_due.push_back(ev);
						end else begin
							ph = PH_ROWS;
						end
					end else if (ph == PH_ROWS) begin
						rows = word;
						ph = PH_COLS;
					end else begin
						cols = word;
						pc = rows * cols;
						pc3 = pc * 32'd3;
						ph = PH_DATA;
						remaining = data_len;
						pix_idx = '0;
						partial = '0;
						first_due = 1'b1;
						// RGB wins when both sizes match
						if (data_len == pc3) begin
							mode = MODE_RGB;
						end else if (data_len == pc) begin
							mode = MODE_GRAY;
						end else begin
							mode = MODE_SKIP;
							ev.event_kind = EV_UNSUPPORTED;
							ev.frame_width = cols;
							ev.frame_height = rows;
							events_due.push_back(ev);
						end
					end
				end
				PH_DATA: begin
					remaining--;
					last = (remaining == 0);
					if (last) restart_hunt();
					if (mode == MODE_GRAY) begin
						due_pixel(b, b, b, 1'b1, last);
					end else if (mode == MODE_RGB) begin
						// bytes come in as blue, green, red
						if (pix_idx == 2'd0) begin
							partial = {8'h00, b};
							pix_idx = 2'd1;
						end else if (pix_idx == 2'd1) begin
							partial[15:8] = b;
							pix_idx = 2'd2;
						end else begin
							pix_idx = 2'd0;
							due_pixel(b, partial[15:8], partial[7:0], 1'b0, last);
						end
					end
				end
				default: begin
					// slide the window; a full window needs three earlier bytes
					if (fill == 2'd3 && {window, b} == magic) begin
						ph = PH_LEN;
						window = '0;
						fill = '0;
						hdr = '0;
						hdr_cnt = '0;
					end else begin
						ph = PH_HUNT;
						window = {window[15:0], b};
						if (fill != 2'd3) fill++;
					end
				end
			endcase
		endfunction

		function void check_event(result_t got);
			result_t want;
			if (events_due.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("tb: result with none due: kind %0d rgb %02h %02h %02h",
						got.event_kind, got.red, got.green, got.blue);
				return;
			end
			want = events_due.pop_front();
			if (got.event_kind !== want.event_kind || got.red !== want.red ||
				got.green !== want.green || got.blue !== want.blue ||
				got.is_gray !== want.is_gray || got.frame_width !== want.frame_width ||
				got.frame_height !== want.frame_height ||
				got.first_pixel !== want.first_pixel || got.last_pixel !== want.last_pixel) begin
				failures++;
				if (failures <= 10)
					$display("tb: mismatch want kind %0d rgb %02h %02h %02h",
						want.event_kind, want.red, want.green, want.blue,
						" gray %0b w %0d h %0d first %0b last %0b",
						want.is_gray, want.frame_width, want.frame_height,
						want.first_pixel, want.last_pixel,
						" / got kind %0d rgb %02h %02h %02h",
						got.event_kind, got.red, got.green, got.blue,
						" gray %0b w %0d h %0d first %0b last %0b",
						got.is_gray, got.frame_width, got.frame_height,
						got.first_pixel, got.last_pixel);
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	reg_idx_t           cfg_index;
	logic [WORD_W-1:0]  cfg_wdata;

	ifd_byte_if rx_if();
	ifd_pix_if  px_if();

	deframe_scoreboard sb = new();

	int bytes_sent = 0;
	int hold_off = 0;
	int quiet_cycles = 0;
	bit sender_steady = 1'b0;
	bit sink_steady = 1'b0;

	image_frame_deframer_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.rx        (rx_if),
		.px        (px_if)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic bit lead_byte_unique(logic [WORD_W-1:0] m);
		return m[31:24] != m[23:16] && m[31:24] != m[15:8] && m[31:24] != m[7:0];
	endfunction

	// offer one word and hold it until taken; valid stays up into the next word
	task automatic send_byte(logic [7:0] b);
		int gap;
		gap = sender_steady ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			rx_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.rx_byte <= b;
		@(posedge clk);
		while (!rx_if.ready) @(posedge clk);
		sb.take_byte(b);
		bytes_sent++;
	endtask

	task automatic send_word(logic [WORD_W-1:0] w);
		for (int i = 0; i < 4; i++) send_byte(w[31 - 8*i -: 8]);
	endtask

	// marker, length, and when the length passes, rows, columns and data
	task automatic send_frame(logic [WORD_W-1:0] len, logic [WORD_W-1:0] rows,
		logic [WORD_W-1:0] cols);
		send_word(sb.magic);
		send_word(len);
		if (len != 0 && len <= sb.max_bytes) begin
			send_word(rows);
			send_word(cols);
			repeat (len) send_byte($urandom_range(0, 255));
		end
	endtask

	task automatic send_random_frame();
		logic [WORD_W-1:0] len;
		logic [WORD_W-1:0] rows;
		logic [WORD_W-1:0] cols;
		logic [WORD_W-1:0] tmp;
		frame_shape_t      shape;
		int                r;
		int                c;
		int                k;
		// noise and false starts only where they cannot overlap the marker
		if (lead_byte_unique(sb.magic)) begin
			repeat ($urandom_range(0, 3)) send_byte($urandom_range(0, 255));
			if ($urandom_range(0, 3) == 0) begin
				k = $urandom_range(1, 3);
				for (int i = 0; i < k; i++) send_byte(sb.magic[31 - 8*i -: 8]);
			end
		end
		sender_steady = ($urandom_range(0, 3) == 0);
		r = $urandom_range(1, 3);
		c = $urandom_range(1, 4);
		rows = r;
		cols = c;
		shape = frame_shape_t'($urandom_range(0, 5));
		case (shape)
			SHAPE_RGB: len = r * c * 3;
			SHAPE_GRAY: len = r * c;
			SHAPE_REJECT: begin
				if (sb.max_bytes == ALL_ONES || $urandom_range(0, 1) == 0)
					len = 0;
				else
					len = $urandom_range(ALL_ONES, sb.max_bytes + 1);
			end
			SHAPE_UNSUPPORTED: begin
				rows = $urandom();
				cols = $urandom();
				len = $urandom_range(1, 12);
			end
			SHAPE_WRAPPED: begin
				// (2^31 + r) * 2c wraps to 2rc
				rows = 32'h8000_0000 + r;
				cols = 2 * c;
				len = ($urandom_range(0, 1) == 0) ? 2 * r * c : 6 * r * c;
			end
			default: begin
				// length not a multiple of three in RGB mode
				if ($urandom_range(0, 1) == 0) begin
					len = 2;
					rows = 2;
					cols = 32'h2AAA_AAAB;
				end else begin
					len = 1;
					rows = 1;
					cols = 32'hAAAA_AAAB;
				end
			end
		endcase
		if ($urandom_range(0, 1) == 0) begin
			tmp = rows;
			rows = cols;
			cols = tmp;
		end
		send_frame(len, rows, cols);
	endtask

	// drain, let skipped bytes clear the pipe, then write both registers
	task automatic reconfigure(logic [WORD_W-1:0] m, logic [WORD_W-1:0] mx);
		rx_if.valid <= 1'b0;
		while (sb.events_due.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_MAGIC;
		cfg_wdata <= m;
		@(posedge clk);
		sb.set_reg(REG_MAGIC, m);
		cfg_index <= REG_MAX_BYTES;
		cfg_wdata <= mx;
		@(posedge clk);
		sb.set_reg(REG_MAX_BYTES, mx);
		cfg_we <= 1'b0;
	endtask

	// sink: random stalls per result, steady stretches, one long hold-off
	initial begin
		int stall;
		int n;
		px_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off != 0) begin
				n = hold_off;
				hold_off = 0;
				px_if.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			stall = sink_steady ? 0 : $urandom_range(0, 4);
			if (stall != 0) begin
				px_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			px_if.ready <= 1'b1;
			@(posedge clk);
			while (!px_if.valid) @(posedge clk);
			if ($urandom_range(0, 19) == 0) sink_steady = !sink_steady;
		end
	end

	// check every result taken
	always @(posedge clk) begin
		result_t seen;
		if (arst_n && px_if.valid && px_if.ready) begin
			seen = '0;
			seen.valid = 1'b1;
			seen.event_kind = px_if.event_kind;
			seen.red = px_if.red;
			seen.green = px_if.green;
			seen.blue = px_if.blue;
			seen.is_gray = px_if.is_gray;
			seen.frame_width = px_if.frame_width;
			seen.frame_height = px_if.frame_height;
			seen.first_pixel = px_if.first_pixel;
			seen.last_pixel = px_if.last_pixel;
			sb.check_event(seen);
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (rx_if.valid && rx_if.ready) || (px_if.valid && px_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		logic [WORD_W-1:0] rand_magic;
		logic [WORD_W-1:0] rand_max;
		int                goal;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_MAGIC;
		cfg_wdata <= '0;
		rx_if.valid <= 1'b0;
		rx_if.rx_byte <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: each frame kind and the wrap corners
		send_frame(12, 2, 2);
		send_frame(2, 1, 2);
		send_frame(0, 0, 0);
		send_frame(MAX_BYTES_RST + 1, 0, 0);
		send_frame(ALL_ONES, 0, 0);
		send_frame(5, ALL_ONES, ALL_ONES);
		send_frame(3, 0, 0);
		send_frame(2, 2, 32'h2AAA_AAAB);
		send_frame(1, 1, 32'hAAAA_AAAB);
		send_frame(2, 32'h8000_0001, 2);
		send_frame(6, 2, 32'h8000_0001);
		goal = bytes_sent + 150;
		while (bytes_sent < goal) send_random_frame();

		// random marker and a small limit; hold the sink off midway
		do rand_magic = $urandom(); while (!lead_byte_unique(rand_magic));
		rand_max = $urandom_range(12, 64);
		reconfigure(rand_magic, rand_max);
		send_frame(rand_max, 7, 7);
		send_frame(rand_max + 1, 7, 7);
		goal = bytes_sent + 300;
		while (bytes_sent < goal) send_random_frame();
		hold_off = HOLD_OFF_CYCLES;
		goal = bytes_sent + 300;
		while (bytes_sent < goal) send_random_frame();

		// all-zero marker with limits of zero and one
		reconfigure('0, '0);
		repeat (5) send_random_frame();
		reconfigure('0, 32'd1);
		goal = bytes_sent + 150;
		while (bytes_sent < goal) send_random_frame();

		// all-ones marker and limit
		reconfigure(ALL_ONES, ALL_ONES);
		goal = bytes_sent + 400;
		while (bytes_sent < goal) send_random_frame();

		// back to the usual marker
		reconfigure(MAGIC_RST, $urandom_range(20, 200));
		goal = bytes_sent + 300;
		while (bytes_sent < goal) send_random_frame();

		// both sizes match at 2^31; only the first pixels can be sent
		reconfigure(MAGIC_RST, ALL_ONES);
		send_word(MAGIC_RST);
		send_word(32'h8000_0000);
		send_word(32'h8000_0000);
		send_word(32'd1);
		repeat (9) send_byte($urandom_range(0, 255));

		rx_if.valid <= 1'b0;
		while (sb.events_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.failures == 0 && sb.events_due.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
